// ----- rtl/brb_pkg.sv -----
package brb_pkg;

	// Field widths fixed by the interface.
	localparam int MODE_W = 3;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 12;
	localparam int CAP_W  = 13;
	localparam int ST_W   = 2;

	localparam int DEPTH_DFLT  = 4096;
	localparam int CAP_RST     = 4096;
	localparam int CAP_MIN     = 2;
	localparam int BLANK_SLOTS = 1;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SKIP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd4;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_DATA  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic cfg_wr;
	} cmd_t;

endpackage

// ----- rtl/brb_ctrl.sv -----
module brb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cfg_valid,
	output logic              busy,
	output logic              cfg_ready,
	output logic              done,
	output brb_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   accept;

	assign busy      = (state_q == S_EXEC);
	// A request entering at the same edge takes priority over a capacity write.
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign done      = (state_q == S_RESP);
	assign accept    = start && !busy;

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_n = S_EXEC;
			end
			S_EXEC: begin
				state_n = S_RESP;
			end
			S_RESP: begin
				// A new request may enter while the result is on the ports.
				state_n = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		cmd.load   = accept;
		cmd.exec   = (state_q == S_EXEC);
		cmd.cfg_wr = cfg_valid && cfg_ready;
	end

endmodule

// ----- rtl/brb_dp.sv -----
module brb_dp #(
	parameter int DEPTH = brb_pkg::DEPTH_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  brb_pkg::cmd_t               cmd,
	input  logic [brb_pkg::MODE_W-1:0]  mode,
	input  logic [brb_pkg::DATA_W-1:0]  data_in,
	input  logic [brb_pkg::CNT_W-1:0]   offset,
	input  logic [brb_pkg::CNT_W-1:0]   count,
	input  logic [brb_pkg::CAP_W-1:0]   cfg_data,
	output logic [brb_pkg::DATA_W-1:0]  data_out,
	output logic [brb_pkg::ST_W-1:0]    status,
	output logic [brb_pkg::CNT_W-1:0]   used_bytes,
	output logic [brb_pkg::CNT_W-1:0]   free_bytes,
	output logic [brb_pkg::CNT_W-1:0]   read_span,
	output logic [brb_pkg::CNT_W-1:0]   write_span
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int OW = brb_pkg::CNT_W;
	localparam int CAP_RST_EFF =
		(brb_pkg::CAP_RST > DEPTH) ? DEPTH : brb_pkg::CAP_RST;

	logic [brb_pkg::DATA_W-1:0] mem [DEPTH];

	// Request fields, captured at accept.
	logic [brb_pkg::MODE_W-1:0] mode_q;
	logic [brb_pkg::DATA_W-1:0] data_q;
	logic [brb_pkg::CNT_W-1:0]  offset_q;
	logic [brb_pkg::CNT_W-1:0]  count_q;

	logic [CW-1:0]             cap_q;
	logic [PW-1:0]             rp_q;
	logic [PW-1:0]             wp_q;
	logic [CW-1:0]             used_q;
	logic [CW-1:0]             free_q;
	logic [brb_pkg::ST_W-1:0]  st_q;
	logic                      rd_ok_q;
	logic [brb_pkg::DATA_W-1:0] rdata_q;

	logic [PW-1:0]            base;
	logic [CW-1:0]            inc;
	logic [SW-1:0]            sum;
	logic [SW-1:0]            wrapped;
	logic [PW-1:0]            wrap_ptr;
	logic [PW-1:0]            rd_addr;
	logic [brb_pkg::ST_W-1:0] st;
	logic                     rd_ok;
	logic                     wr_en;
	logic                     adv_rp;
	logic                     adv_wp;
	logic                     grow;
	logic                     shrink;
	logic [CW-1:0]            cap_n;

	logic [CW-1:0] rp_w;
	logic [CW-1:0] wp_w;
	logic [CW-1:0] rspan;
	logic [CW-1:0] wspan;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			data_q   <= data_in;
			offset_q <= offset;
			count_q  <= count;
		end
	end

	always_comb begin
		base   = rp_q;
		inc    = CW'(1);
		st     = brb_pkg::ST_OK;
		rd_ok  = 1'b0;
		wr_en  = 1'b0;
		adv_rp = 1'b0;
		adv_wp = 1'b0;
		grow   = 1'b0;
		shrink = 1'b0;
		case (mode_q)
			brb_pkg::MODE_PUT: begin
				base = wp_q;
				if (free_q == '0) begin
					st = brb_pkg::ST_NO_SPACE;
				end else begin
					wr_en  = 1'b1;
					adv_wp = 1'b1;
					grow   = 1'b1;
				end
			end
			brb_pkg::MODE_GET: begin
				if (used_q == '0) begin
					st = brb_pkg::ST_NO_DATA;
				end else begin
					rd_ok  = 1'b1;
					adv_rp = 1'b1;
					shrink = 1'b1;
				end
			end
			brb_pkg::MODE_PEEK: begin
				inc = CW'(offset_q);
				if (32'(offset_q) >= 32'(used_q)) begin
					st = brb_pkg::ST_NO_DATA;
				end else begin
					rd_ok = 1'b1;
				end
			end
			brb_pkg::MODE_SKIP: begin
				inc = CW'(count_q);
				if (32'(count_q) > 32'(used_q)) begin
					st = brb_pkg::ST_NO_DATA;
				end else begin
					adv_rp = 1'b1;
					shrink = 1'b1;
				end
			end
			brb_pkg::MODE_COMMIT: begin
				base = wp_q;
				inc  = CW'(count_q);
				if (32'(count_q) > 32'(free_q)) begin
					st = brb_pkg::ST_NO_SPACE;
				end else begin
					adv_wp = 1'b1;
					grow   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// The advance never exceeds the capacity, so one subtract wraps it.
	assign sum      = SW'(base) + SW'(inc);
	assign wrapped  = (sum >= SW'(cap_q)) ? (sum - SW'(cap_q)) : sum;
	assign wrap_ptr = PW'(wrapped);
	assign rd_addr  = (mode_q == brb_pkg::MODE_PEEK) ? wrap_ptr : rp_q;

	always_comb begin
		if (cfg_data < brb_pkg::CAP_W'(brb_pkg::CAP_MIN)) begin
			cap_n = CW'(brb_pkg::CAP_MIN);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cap_n = CW'(DEPTH);
		end else begin
			cap_n = CW'(cfg_data);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rdata_q <= mem[rd_addr];
			if (wr_en) mem[wp_q] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CW'(CAP_RST_EFF);
			rp_q    <= '0;
			wp_q    <= '0;
			used_q  <= '0;
			free_q  <= CW'(CAP_RST_EFF - brb_pkg::BLANK_SLOTS);
			st_q    <= brb_pkg::ST_OK;
			rd_ok_q <= 1'b0;
		end else if (cmd.cfg_wr) begin
			// A new capacity empties the buffer.
			cap_q  <= cap_n;
			rp_q   <= '0;
			wp_q   <= '0;
			used_q <= '0;
			free_q <= cap_n - CW'(brb_pkg::BLANK_SLOTS);
		end else if (cmd.exec) begin
			st_q    <= st;
			rd_ok_q <= rd_ok;
			if (adv_rp) rp_q <= wrap_ptr;
			if (adv_wp) wp_q <= wrap_ptr;
			if (grow) begin
				used_q <= used_q + inc;
				free_q <= free_q - inc;
			end else if (shrink) begin
				used_q <= used_q - inc;
				free_q <= free_q + inc;
			end
		end
	end

	assign rp_w = CW'(rp_q);
	assign wp_w = CW'(wp_q);

	always_comb begin
		if (rp_w <= wp_w) begin
			rspan = wp_w - rp_w;
		end else begin
			rspan = cap_q - rp_w;
		end
		if (wp_w < rp_w) begin
			wspan = rp_w - wp_w - CW'(brb_pkg::BLANK_SLOTS);
		end else if (rp_w == '0) begin
			// The blank slot sits at the end of the ring, just below the capacity.
			wspan = cap_q - wp_w - CW'(brb_pkg::BLANK_SLOTS);
		end else begin
			wspan = cap_q - wp_w;
		end
	end

	assign data_out   = rd_ok_q ? rdata_q : '0;
	assign status     = st_q;
	assign used_bytes = OW'(used_q);
	assign free_bytes = OW'(free_q);
	assign read_span  = OW'(rspan);
	assign write_span = OW'(wspan);

endmodule

// ----- rtl/byte_ring_buffer_core.sv -----
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------
// request   | start, busy                | mode, data_in, offset, count
// result    | done (one-cycle strobe)    | data_out, status, used_bytes, free_bytes,
//           |                            | read_span, write_span
// config    | cfg_valid, cfg_ready       | cfg_data (capacity)
//
// A request accepted at one edge executes in the next cycle, where the store is read
// or written; its result is strobed on done in the cycle after that.
// A new request is taken in the cycle that shows the result, not while one executes:
// busy is high while the store is read or written, and the read is registered.
// Reset empties the buffer at once, capacity min(4096, DEPTH); the store needs no clearing.
// The result side cannot stall; cfg_ready is high only while no request is in flight.
module byte_ring_buffer_core #(
	parameter int DEPTH = brb_pkg::DEPTH_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [brb_pkg::MODE_W-1:0]  mode,
	input  logic [brb_pkg::DATA_W-1:0]  data_in,
	input  logic [brb_pkg::CNT_W-1:0]   offset,
	input  logic [brb_pkg::CNT_W-1:0]   count,
	output logic                        done,
	output logic [brb_pkg::DATA_W-1:0]  data_out,
	output logic [brb_pkg::ST_W-1:0]    status,
	output logic [brb_pkg::CNT_W-1:0]   used_bytes,
	output logic [brb_pkg::CNT_W-1:0]   free_bytes,
	output logic [brb_pkg::CNT_W-1:0]   read_span,
	output logic [brb_pkg::CNT_W-1:0]   write_span,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [brb_pkg::CAP_W-1:0]   cfg_data
);

	brb_pkg::cmd_t cmd;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	brb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.data_in    (data_in),
		.offset     (offset),
		.count      (count),
		.cfg_data   (cfg_data),
		.data_out   (data_out),
		.status     (status),
		.used_bytes (used_bytes),
		.free_bytes (free_bytes),
		.read_span  (read_span),
		.write_span (write_span)
	);

`ifndef SYNTHESIS
	a_accept_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 done)
		else $error("accepted request did not produce a result two cycles later");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobed without a preceding execute cycle");

	a_reject_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != brb_pkg::ST_OK)) |-> (data_out == '0))
		else $error("rejected request returned a nonzero byte");

	a_no_cfg_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(busy || done) |-> !cfg_ready)
		else $error("configuration accepted while a request is in flight");
`endif

endmodule

// ----- dv/byte_ring_buffer_core_tb.sv -----
module byte_ring_buffer_core_tb;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int STORE_DEPTH = brb_pkg::DEPTH_DFLT;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_MAX = (1 << brb_pkg::CNT_W) - 1;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 60;

	typedef logic [brb_pkg::MODE_W-1:0] mode_t;
	typedef logic [brb_pkg::DATA_W-1:0] data_t;
	typedef logic [brb_pkg::CNT_W-1:0]  cnt_t;
	typedef logic [brb_pkg::CAP_W-1:0]  cap_t;
	typedef logic [brb_pkg::ST_W-1:0]   st_t;
	typedef logic [IDX_W-1:0]           idx_t;

	localparam mode_t MODE_LAST = '1;
	localparam cap_t CAP_ALL_ONES = '1;

	typedef struct packed {
		data_t data;
		st_t   status;
		cnt_t  stored;
		cnt_t  room;
		cnt_t  rspan;
		cnt_t  wspan;
	} ring_report_t;

	class ring_buffer_tracker;
		data_t slots [STORE_DEPTH];
		bit written [STORE_DEPTH];
		int unsigned rd_ptr;
		int unsigned wr_ptr;
		cap_t cap_reg;
		ring_report_t pending_reports [$];
		int errors;

		function new();
			rd_ptr = 0;
			wr_ptr = 0;
			cap_reg = cap_t'(brb_pkg::CAP_RST);
			errors = 0;
		endfunction

		function int unsigned eff_cap();
			if (cap_reg < brb_pkg::CAP_MIN)
				return brb_pkg::CAP_MIN;
			if (cap_reg > STORE_DEPTH)
				return STORE_DEPTH;
			return 32'(cap_reg);
		endfunction

		function int unsigned used();
			if (wr_ptr >= rd_ptr)
				return wr_ptr - rd_ptr;
			return eff_cap() - rd_ptr + wr_ptr;
		endfunction

		function int unsigned room();
			return eff_cap() - brb_pkg::BLANK_SLOTS - used();
		endfunction

		// True when the slot at this distance past the read point has ever been written by a put.
		function bit readable(int unsigned ofs);
			return written[idx_t'((rd_ptr + ofs) % eff_cap())];
		endfunction

		function void load_capacity(cap_t value);
			cap_reg = value;
			rd_ptr = 0;
			wr_ptr = 0;
		endfunction

		function void apply_request(mode_t op, data_t din, cnt_t ofs, cnt_t cnt);
			int unsigned c;
			int unsigned fill;
			int unsigned rspan;
			int unsigned wspan;
			ring_report_t r;
			c = eff_cap();
			fill = used();
			r = '0;
			r.status = brb_pkg::ST_OK;
			case (op)
				brb_pkg::MODE_PUT: begin
					if (room() < 1) begin
						r.status = brb_pkg::ST_NO_SPACE;
					end else begin
						slots[idx_t'(wr_ptr)] = din;
						written[idx_t'(wr_ptr)] = 1'b1;
						wr_ptr = (wr_ptr + 1) % c;
					end
				end
				brb_pkg::MODE_GET: begin
					if (fill < 1) begin
						r.status = brb_pkg::ST_NO_DATA;
					end else begin
						r.data = slots[idx_t'(rd_ptr)];
						rd_ptr = (rd_ptr + 1) % c;
					end
				end
				brb_pkg::MODE_PEEK: begin
					if (ofs >= fill)
						r.status = brb_pkg::ST_NO_DATA;
					else
						r.data = slots[idx_t'((rd_ptr + ofs) % c)];
				end
				brb_pkg::MODE_SKIP: begin
					if (cnt > fill)
						r.status = brb_pkg::ST_NO_DATA;
					else
						rd_ptr = (rd_ptr + cnt) % c;
				end
				brb_pkg::MODE_COMMIT: begin
					if (cnt > room())
						r.status = brb_pkg::ST_NO_SPACE;
					else
						wr_ptr = (wr_ptr + cnt) % c;
				end
				default: ;
			endcase
			if (rd_ptr <= wr_ptr)
				rspan = wr_ptr - rd_ptr;
			else
				rspan = c - rd_ptr;
			if (wr_ptr < rd_ptr)
				wspan = rd_ptr - wr_ptr - brb_pkg::BLANK_SLOTS;
			else if (rd_ptr < brb_pkg::BLANK_SLOTS)
				wspan = c - wr_ptr - brb_pkg::BLANK_SLOTS + rd_ptr;
			else
				wspan = c - wr_ptr;
			fill = used();
			r.stored = fill[brb_pkg::CNT_W-1:0];
			fill = room();
			r.room = fill[brb_pkg::CNT_W-1:0];
			r.rspan = rspan[brb_pkg::CNT_W-1:0];
			r.wspan = wspan[brb_pkg::CNT_W-1:0];
			pending_reports.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void match_result(ring_report_t got);
			ring_report_t want;
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, expected none, actual %h",
					$time, got);
			end else begin
				want = pending_reports.pop_front();
				compare_field("data_out", 32'(want.data), 32'(got.data));
				compare_field("status", 32'(want.status), 32'(got.status));
				compare_field("used_bytes", 32'(want.stored), 32'(got.stored));
				compare_field("free_bytes", 32'(want.room), 32'(got.room));
				compare_field("read_span", 32'(want.rspan), 32'(got.rspan));
				compare_field("write_span", 32'(want.wspan), 32'(got.wspan));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mode_t mode = '0;
	data_t data_in = '0;
	cnt_t offset = '0;
	cnt_t count = '0;
	logic done;
	data_t data_out;
	st_t status;
	cnt_t used_bytes;
	cnt_t free_bytes;
	cnt_t read_span;
	cnt_t write_span;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cap_t cfg_data = '0;

	ring_buffer_tracker tracker = new();
	int burst_left = 0;
	int cycle_cnt = 0;

	byte_ring_buffer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.data_in(data_in),
		.offset(offset),
		.count(count),
		.done(done),
		.data_out(data_out),
		.status(status),
		.used_bytes(used_bytes),
		.free_bytes(free_bytes),
		.read_span(read_span),
		.write_span(write_span),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.match_result({data_out, status, used_bytes, free_bytes,
				read_span, write_span});
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[byte_ring_buffer_core] ERROR");
		$finish;
	end

	function automatic data_t rnd_data();
		return data_t'($urandom);
	endfunction

	function automatic cnt_t rnd_cnt();
		return cnt_t'($urandom);
	endfunction

	// Holds the request until the block takes it, then records the expected report.
	task automatic issue(input mode_t op, input data_t din, input cnt_t ofs, input cnt_t cnt);
		start <= 1'b1;
		mode <= op;
		data_in <= din;
		offset <= ofs;
		count <= cnt;
		do @(posedge clk); while (busy);
		tracker.apply_request(op, din, ofs, cnt);
	endtask

	task automatic paced_issue(input mode_t op, input data_t din, input cnt_t ofs,
			input cnt_t cnt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		issue(op, din, ofs, cnt);
		burst_left--;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input cap_t value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.load_capacity(value);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic; reads are steered away from slots never written.
	task automatic random_item();
		mode_t op;
		data_t din;
		cnt_t ofs;
		cnt_t cnt;
		int unsigned pick;
		int unsigned fill;
		int unsigned space;
		din = rnd_data();
		ofs = rnd_cnt();
		cnt = rnd_cnt();
		fill = tracker.used();
		space = tracker.room();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			op = brb_pkg::MODE_PUT;
		end else if (pick < 55) begin
			op = brb_pkg::MODE_GET;
			if (fill > 0 && !tracker.readable(0)) begin
				op = brb_pkg::MODE_SKIP;
				cnt = cnt_t'(1);
			end
		end else if (pick < 70) begin
			op = brb_pkg::MODE_PEEK;
			if (fill > 0 && $urandom_range(0, 3) != 0)
				ofs = cnt_t'($urandom_range(0, fill - 1));
			if (ofs < fill && !tracker.readable(32'(ofs)))
				ofs = cnt_t'($urandom_range(fill, CNT_MAX));
		end else if (pick < 80) begin
			op = brb_pkg::MODE_SKIP;
			if ($urandom_range(0, 2) != 0)
				cnt = cnt_t'($urandom_range(0, fill));
		end else if (pick < 93) begin
			op = brb_pkg::MODE_COMMIT;
			case ($urandom_range(0, 3))
				0: ;
				1: cnt = cnt_t'($urandom_range(0, space));
				default: cnt = cnt_t'($urandom_range(0, (space < 4) ? space : 4));
			endcase
		end else begin
			op = mode_t'($urandom_range(brb_pkg::MODE_COMMIT + 1, MODE_LAST));
		end
		paced_issue(op, din, ofs, cnt);
	endtask

	initial begin
		cap_t phase_caps [PHASES];
		phase_caps = '{cap_t'(brb_pkg::CAP_MIN), cap_t'(1), cap_t'(3), cap_t'(5), cap_t'(16),
			cap_t'(brb_pkg::CAP_RST), cap_t'(brb_pkg::CAP_RST + 1), CAP_ALL_ONES,
			cap_t'(33), cap_t'(0), cap_t'(0), cap_t'(brb_pkg::CAP_RST)};
		phase_caps[9] = cap_t'($urandom_range(brb_pkg::CAP_MIN, 64));
		phase_caps[10] = cap_t'($urandom_range(65, brb_pkg::CAP_RST));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty buffer at reset capacity refuses gets, peeks and nonzero skips; two puts follow.
		paced_issue(brb_pkg::MODE_GET, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PEEK, rnd_data(), cnt_t'(0), rnd_cnt());
		paced_issue(brb_pkg::MODE_PEEK, rnd_data(), cnt_t'(CNT_MAX), rnd_cnt());
		paced_issue(brb_pkg::MODE_SKIP, rnd_data(), rnd_cnt(), cnt_t'(0));
		paced_issue(brb_pkg::MODE_COMMIT, rnd_data(), rnd_cnt(), cnt_t'(0));
		paced_issue(brb_pkg::MODE_SKIP, rnd_data(), rnd_cnt(), cnt_t'(1));
		paced_issue(brb_pkg::MODE_SKIP, rnd_data(), rnd_cnt(), cnt_t'(CNT_MAX));
		paced_issue(brb_pkg::MODE_COMMIT + 1'b1, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(MODE_LAST, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'h00, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'hFF, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_COMMIT, rnd_data(), rnd_cnt(), cnt_t'(CNT_MAX));
		paced_issue(brb_pkg::MODE_PEEK, rnd_data(), cnt_t'(1), rnd_cnt());
		paced_issue(brb_pkg::MODE_PEEK, rnd_data(), cnt_t'(2), rnd_cnt());
		paced_issue(brb_pkg::MODE_GET, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_GET, rnd_data(), rnd_cnt(), rnd_cnt());

		// Small ring: fill, overflow, wrap the write pointer, peek, and wrap the read pointer by a skip.
		write_capacity(cap_t'(4));
		paced_issue(brb_pkg::MODE_PUT, 8'h5A, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'hA5, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'h3C, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'h99, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_COMMIT, rnd_data(), rnd_cnt(), cnt_t'(1));
		paced_issue(brb_pkg::MODE_GET, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PUT, 8'hC3, rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_PEEK, rnd_data(), cnt_t'(2), rnd_cnt());
		paced_issue(brb_pkg::MODE_SKIP, rnd_data(), rnd_cnt(), cnt_t'(3));

		// Oversized capacity clamps to the full store; commit fills it without data.
		write_capacity(CAP_ALL_ONES);
		paced_issue(brb_pkg::MODE_COMMIT, rnd_data(), rnd_cnt(), cnt_t'(CNT_MAX));
		paced_issue(brb_pkg::MODE_PUT, rnd_data(), rnd_cnt(), rnd_cnt());
		paced_issue(brb_pkg::MODE_SKIP, rnd_data(), rnd_cnt(), cnt_t'(CNT_MAX));

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_item();
				if ($urandom_range(0, 40) == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
			$display("[byte_ring_buffer_core] OK");
		else
			$display("[byte_ring_buffer_core] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/brb_pkg.sv
rtl/brb_ctrl.sv
rtl/brb_dp.sv
rtl/byte_ring_buffer_core.sv
dv/byte_ring_buffer_core_tb.sv
